// File: rtl/utf8_to_utf16_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define U8U16_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 check failed");
// Next-cycle implication, checked outside reset.
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 check failed");
`else
`define U8U16_ASSERT(label, clk, rst_n, ante, cons)
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/u8u16_pkg.sv
package u8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;

    // Results of one decoded byte: an optional code unit, then an optional terminator.
    typedef struct packed {
        logic              has_unit;
        logic [UNIT_W-1:0] unit;
        logic              has_end;
        logic [UNIT_W-1:0] count;
    } t_pair;

endpackage

// File: rtl/u8u16_decode.sv
`include "utf8_to_utf16_decoder_macros.svh"

module u8u16_decode #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [u8u16_pkg::UNIT_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]      i_in_byte,
    input  logic                              i_in_last,
    output logic                              o_pair_valid,
    input  logic                              i_pair_ready,
    output u8u16_pkg::t_pair                  o_pair
);
    import u8u16_pkg::*;

    localparam int CMP_W = (COUNT_BITS > UNIT_W) ? COUNT_BITS : UNIT_W;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;

    logic [UNIT_W-1:0]     r_limit;
    logic                  r_in_v;
    logic [BYTE_W-1:0]     r_in_byte;
    logic                  r_in_last;
    logic [1:0]            r_need;
    logic [9:0]            r_part;
    logic [COUNT_BITS-1:0] r_pos;
    logic [COUNT_BITS-1:0] r_units;

    logic [1:0]            n_need;
    logic [9:0]            n_part;
    logic [COUNT_BITS-1:0] n_pos;
    logic [COUNT_BITS-1:0] n_units;
    logic                  have_unit;
    logic [UNIT_W-1:0]     unit;
    logic [UNIT_W-1:0]     acc;
    logic                  is_cont;
    logic                  below_limit;
    logic                  consume;
    logic                  has_result;

    // Decode the registered byte against the pending sequence.
    always_comb begin
        is_cont     = (r_need != NEED_NONE) && (r_in_byte[7:6] == 2'b10);
        acc         = {r_part, r_in_byte[5:0]};
        below_limit = CMP_W'(r_pos) < CMP_W'(r_limit);
        have_unit   = 1'b0;
        unit        = '0;
        n_need      = NEED_NONE;
        n_part      = '0;
        if (is_cont) begin
            if (r_need == NEED_ONE) begin
                unit      = acc;
                have_unit = 1'b1;
            end else begin
                n_need = NEED_ONE;
                n_part = acc[9:0];
            end
        end else if (below_limit) begin
            if (!r_in_byte[7]) begin
                unit      = {8'd0, r_in_byte};
                have_unit = 1'b1;
            end else if (r_in_byte[7:5] == 3'b110) begin
                n_need = NEED_ONE;
                n_part = {5'd0, r_in_byte[4:0]};
            end else if (r_in_byte[7:4] == 4'b1110) begin
                n_need = NEED_TWO;
                n_part = {6'd0, r_in_byte[3:0]};
            end
        end
        n_pos   = (r_pos != '1) ? r_pos + 1'b1 : r_pos;
        n_units = (have_unit && (r_units != '1)) ? r_units + 1'b1 : r_units;
    end

    // Handshake toward the output stage; bytes without results drain freely.
    assign has_result   = have_unit || r_in_last;
    assign consume      = r_in_v && (i_pair_ready || !has_result);
    assign o_in_ready   = !r_in_v || consume;
    assign o_pair_valid = r_in_v && has_result;

    always_comb begin
        o_pair.has_unit = have_unit;
        o_pair.unit     = unit;
        o_pair.has_end  = r_in_last;
        o_pair.count    = UNIT_W'(n_units);
    end

    // Input word register, byte limit and stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= '1;
            r_in_v  <= 1'b0;
            r_need  <= NEED_NONE;
            r_part  <= '0;
            r_pos   <= '0;
            r_units <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_v <= i_in_valid;
            end
            if (consume) begin
                if (r_in_last) begin
                    r_need  <= NEED_NONE;
                    r_part  <= '0;
                    r_pos   <= '0;
                    r_units <= '0;
                end else begin
                    r_need  <= n_need;
                    r_part  <= n_part;
                    r_pos   <= n_pos;
                    r_units <= n_units;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    `U8U16_ASSERT(a_need_range, i_clk, i_rst_n, 1'b1, r_need != 2'd3)
    `U8U16_ASSERT_NEXT(a_clear_on_last, i_clk, i_rst_n, consume && r_in_last,
        (r_pos == '0) && (r_units == '0) && (r_need == NEED_NONE))

endmodule

// File: rtl/u8u16_out.sv
`include "utf8_to_utf16_decoder_macros.svh"

module u8u16_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pair_valid,
    output logic                          o_pair_ready,
    input  u8u16_pkg::t_pair              i_pair,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*u8u16_pkg::UNIT_W-1:0] o_data,
    output logic                          o_last
);
    import u8u16_pkg::*;

    logic              r_pv;
    logic              r_unit_p;
    logic              r_end_p;
    logic [UNIT_W-1:0] r_unit;
    logic [UNIT_W-1:0] r_count;
    logic              take;
    logic              both;
    logic              done;

    // The code unit goes out first; the terminator follows when present.
    assign both         = r_unit_p && r_end_p;
    assign take         = r_pv && i_ready;
    assign done         = take && !both;
    assign o_pair_ready = !r_pv || done;
    assign o_valid      = r_pv;
    assign o_last       = !r_unit_p;
    assign o_data       = r_unit_p ? {{UNIT_W{1'b0}}, r_unit} : {r_count, {UNIT_W{1'b0}}};

    // Result register with its pending flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_unit_p <= 1'b0;
            r_end_p  <= 1'b0;
        end else if (i_pair_valid && o_pair_ready) begin
            r_pv     <= 1'b1;
            r_unit_p <= i_pair.has_unit;
            r_end_p  <= i_pair.has_end;
        end else if (take) begin
            if (both) begin
                r_unit_p <= 1'b0;
            end else begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pair_valid && o_pair_ready) begin
            r_unit  <= i_pair.unit;
            r_count <= i_pair.count;
        end
    end

    `U8U16_ASSERT(a_pending, i_clk, i_rst_n, r_pv, r_unit_p || r_end_p)
    `U8U16_ASSERT_NEXT(a_end_follows, i_clk, i_rst_n, take && both,
        r_pv && !r_unit_p && r_end_p)

endmodule

// File: rtl/utf8_to_utf16_decoder.sv
// Path: input word register, combinational decode, then the result register.
// Throughput: one byte per cycle unless the output stalls; a final byte that ends
// a character yields two words, since that register sends unit then terminator.
// Reset: i_rst_n is synchronous, active low; it clears the stream state and
// sets the byte limit to 65535.
module utf8_to_utf16_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,      // byte_limit
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // in_byte
    input  logic        i_s_axis_tlast,  // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // code_unit [15:0], char_count [31:16]
    output logic        o_m_axis_tlast   // is_end
);
    import u8u16_pkg::*;

    t_pair pair;
    logic  pair_valid;
    logic  pair_ready;

    // The limit register takes a word in any cycle.
    assign o_cfg_ready = 1'b1;

    u8u16_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_byte    (i_s_axis_tdata),
        .i_in_last    (i_s_axis_tlast),
        .o_pair_valid (pair_valid),
        .i_pair_ready (pair_ready),
        .o_pair       (pair)
    );

    u8u16_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair_valid (pair_valid),
        .o_pair_ready (pair_ready),
        .i_pair       (pair),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

endmodule

// File: tb/sv/utf8_decode_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, byte and code unit channels of the decoder.
// It keeps its own copy of the decoder state, works out the words that each
// accepted byte must produce, and compares every accepted output word with
// the oldest word still due.
module utf8_decode_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,
    input  logic        i_out_last,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;

    typedef struct {
        logic [15:0] code_unit;
        logic        is_end;
        logic [15:0] char_count;
    } t_unit_word;

    // Words still owed by the decoder, oldest first.
    t_unit_word units_due[$];

    logic [15:0] byte_limit;
    logic [1:0]  conts_left;
    logic [9:0]  payload;
    logic [15:0] byte_pos;
    logic [15:0] units_sent;
    int          mismatches = 0;

    // Drops any pending character and restarts the string counters.
    task automatic restart_string();
        conts_left = '0;
        payload = '0;
        byte_pos = '0;
        units_sent = '0;
    endtask

    // Decodes one accepted byte and queues the words it produces.
    task automatic decode_byte(input logic [7:0] b, input logic ends_string);
        logic        have_unit;
        logic [15:0] unit;
        logic [15:0] merged;
        have_unit = 1'b0;
        unit = '0;
        merged = {payload, b[5:0]};
        if (conts_left != 0 && b[7:6] == CONT_TAG) begin
            if (conts_left == 2'd1) begin
                unit = merged;
                have_unit = 1'b1;
                conts_left = '0;
                payload = '0;
            end else begin
                payload = merged[9:0];
                conts_left = 2'd1;
            end
        end else begin
            // Any byte that is not a continuation throws away a partial character.
            conts_left = '0;
            payload = '0;
            if (byte_pos < byte_limit) begin
                if (b[7] == 1'b0) begin
                    unit = {8'h00, b};
                    have_unit = 1'b1;
                end else if (b[7:5] == LEAD2_TAG) begin
                    conts_left = 2'd1;
                    payload = {5'b0, b[4:0]};
                end else if (b[7:4] == LEAD3_TAG) begin
                    conts_left = 2'd2;
                    payload = {6'b0, b[3:0]};
                end
            end
        end

        if (byte_pos != COUNT_MAX)
            byte_pos = byte_pos + 16'd1;

        if (have_unit) begin
            if (units_sent != COUNT_MAX)
                units_sent = units_sent + 16'd1;
            units_due.push_back('{unit, 1'b0, 16'h0000});
        end

        if (ends_string) begin
            units_due.push_back('{16'h0000, 1'b1, units_sent});
            restart_string();
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // All channels are sampled at the rising edge, before the edge's updates land.
    always @(posedge i_clk) begin
        t_unit_word want;
        if (!i_rst_n) begin
            byte_limit = LIMIT_RESET;
            restart_string();
            units_due.delete();
        end else begin
            // Output words can only stem from bytes taken at earlier edges.
            if (i_out_valid && i_out_ready) begin
                if (units_due.size() == 0) begin
                    $error("output word %h (last %b) arrived with nothing due",
                           i_out_data, i_out_last);
                    mismatches++;
                end else begin
                    want = units_due.pop_front();
                    compare_field("code_unit", want.code_unit, i_out_data[15:0]);
                    compare_field("is_end", {15'b0, want.is_end}, {15'b0, i_out_last});
                    compare_field("char_count", want.char_count, i_out_data[31:16]);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                byte_limit = i_cfg_data;
            if (i_in_valid && i_in_ready)
                decode_byte(i_in_byte, i_in_last);
        end
        o_errors <= mismatches;
        o_pending <= units_due.size();
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 6;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_BYTES = 170;
    localparam int NUM_PHASES = 8;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;

    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;
    logic        m_tlast;

    int          errors;
    int          pending;
    int          cycles = 0;

    // Percent chance of a gap on each side, changed per phase.
    int          send_idle = 0;
    int          recv_idle = 0;

    // Long receiver hold-off, requested once by the stimulus.
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;

    // Bytes of the string being built.
    logic [7:0]  text[$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    utf8_to_utf16_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    utf8_decode_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_byte   (s_tdata),
        .i_in_last   (s_tlast),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .i_out_last  (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offers one byte, after random gaps, and waits until it is taken.
    // Valid is only lowered in a gap so it never toggles within one step.
    task automatic send_word(input logic [7:0] b, input logic ends_string);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= ends_string;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_word(text[i], i == text.size() - 1);
    endtask

    // Waits until every expected word has come out, then lets the pipe drain.
    task automatic settle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Appends one character: mostly well formed, some noise and broken ones.
    task automatic add_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) begin
            text.push_back(8'($urandom_range(127)));
        end else if (pick < 60) begin
            text.push_back(8'hC0 | 8'($urandom_range(31)));
            text.push_back(8'h80 | 8'($urandom_range(63)));
        end else if (pick < 80) begin
            text.push_back(8'hE0 | 8'($urandom_range(15)));
            text.push_back(8'h80 | 8'($urandom_range(63)));
            text.push_back(8'h80 | 8'($urandom_range(63)));
        end else if (pick < 85) begin
            text.push_back(8'($urandom_range(8'hFF, 8'hF0)));
        end else if (pick < 90) begin
            text.push_back(8'($urandom_range(8'hBF, 8'h80)));
        end else if (pick < 95) begin
            // Lead followed by at most one continuation byte, often too few.
            text.push_back(8'($urandom_range(8'hEF, 8'hC0)));
            if ($urandom_range(1) == 1)
                text.push_back(8'h80 | 8'($urandom_range(63)));
        end else begin
            text.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic make_string();
        int chars;
        chars = $urandom_range(10, 1);
        text.delete();
        repeat (chars) add_char();
        // Now and then the string ends inside a character.
        if ($urandom_range(99) < 15)
            text.push_back(8'($urandom_range(8'hEF, 8'hC0)));
    endtask

    initial begin
        logic [15:0] limits [NUM_PHASES];
        int          sent;
        limits = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0002,
                   16'(3 + $urandom_range(37)), 16'h0005, 16'hFFFE, 16'h0008};

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // Directed string: extremes, overlong and surrogate forms, dropped
        // leads, a stray continuation, a broken sequence and a partial end.
        write_limit(16'hFFFF);
        text = '{8'h41, 8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hC0, 8'h80, 8'hDF, 8'hBF,
                 8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF, 8'hED, 8'hA0, 8'h80,
                 8'hF0, 8'hFF, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'h82};
        send_text();
        s_tvalid <= 1'b0;
        settle();

        // Random phases, each with its own limit and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_limit(limits[p]);
            case (p % 4)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 48; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 48; end
                default: begin send_idle = 13; recv_idle = 13; end
            endcase
            if (p == 0)
                hold_go <= 1'b1;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                make_string();
                sent += text.size();
                send_text();
            end
            s_tvalid <= 1'b0;
            settle();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
